// ----- rtl/core/tcpft_pkg.sv -----
// Shared types and constants for the TCP flow feature table.
`default_nettype none
package tcpft_pkg;

  localparam int unsigned FLOW_ENTRIES_DEF = 4096;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd54;
  localparam int unsigned KEY_W         = 96;

  // Flag bits that close a flow
  localparam int unsigned FLAG_FIN = 0;
  localparam int unsigned FLAG_RST = 2;

  // One table record, valid bit included
  typedef struct packed {
    logic        valid;
    logic [63:0] key_addrs;
    logic [31:0] key_ports;
    logic [31:0] count;
    logic [15:0] max_len;
    logic [15:0] min_len;
    logic [47:0] total_len;
    logic [15:0] port;
    logic [47:0] header_bytes;
    logic [63:0] min_gap;
    logic [63:0] last_time;
  } flow_rec_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/tcp_flow_feature_table_unit.sv -----
// Per-flow TCP statistics table with hashed, linearly probed record memory.
`default_nettype none
// A TCP/IPv4 frame header enters per item; short, non-IPv4 and non-TCP frames
// are dropped in the accept cycle. Records live in one single-port-write,
// registered-read memory of FLOW_ENTRIES words, placed by a folded hash of the
// 4-tuple and linear probing. After accept, each probe reads one slot; a hit
// or a free slot gets one read-modify-write, else the next slot is probed, and
// an item that finds neither in a full table is dropped. A FIN or RST packet
// returns the updated record; the record is kept. After reset the block runs a
// clearing pass over every memory word before it takes its first item.
module tcp_flow_feature_table_unit
  import tcpft_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_captured_length,
  input  wire logic [15:0] in_ethertype,
  input  wire logic [7:0]  in_ip_protocol,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [15:0] in_ip_total_length,
  input  wire logic [3:0]  in_ip_header_words,
  input  wire logic [3:0]  in_tcp_data_offset,
  input  wire logic [7:0]  in_tcp_flags,
  input  wire logic [63:0] in_arrival_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_packet_count,
  output logic [15:0]      out_min_payload,
  output logic [15:0]      out_max_payload,
  output logic [47:0]      out_total_payload,
  output logic [15:0]      out_flow_dst_port,
  output logic [47:0]      out_total_header_bytes,
  output logic [63:0]      out_min_gap,
  output logic [63:0]      out_end_time
);

  localparam int unsigned IDX_W = $clog2(FLOW_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

  // Record memory
  flow_rec_t mem [FLOW_ENTRIES];
  flow_rec_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  flow_rec_t        mem_wdata;

  state_t state_r, state_nxt;

  // Item context
  logic [63:0]      key_addrs_r;
  logic [31:0]      key_ports_r;
  logic [15:0]      dport_r;
  logic [15:0]      payload_r;
  logic [3:0]       doff_r;
  logic             close_r;
  logic [63:0]      now_r;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] probe_cnt_r;
  logic [IDX_W-1:0] clr_cnt_r;

  // Output register
  logic        out_valid_r;
  flow_rec_t   out_rec_r;
  logic [63:0] out_end_r;

  logic accept, pass;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] fold, hash_idx;
  logic hit, empty, wrap_done, emit, out_free, commit, drop, probe;
  flow_rec_t base, upd;
  logic [63:0] gap;
  logic [15:0] hdr_len;

  // Frame filter and home slot of the incoming key
  assign accept = in_valid && !in_stall;
  assign pass   = (in_captured_length >= MIN_FRAME_LEN) && (in_ethertype == ETYPE_IPV4) &&
                  (in_ip_protocol == PROTO_TCP);
  assign key    = {in_src_addr, in_dst_addr, in_src_port, in_dst_port};

  always_comb begin
    fold = '0;
    for (int i = 0; i < KEY_W; i++) begin
      fold[i % IDX_W] = fold[i % IDX_W] ^ key[i];
    end
  end

  assign hash_idx = ({1'b0, fold} >= (IDX_W+1)'(FLOW_ENTRIES)) ?
                    (fold - IDX_W'(FLOW_ENTRIES)) : fold;

  // Probe result
  assign hit       = rd_data_r.valid && (rd_data_r.key_addrs == key_addrs_r) &&
                     (rd_data_r.key_ports == key_ports_r);
  assign empty     = !rd_data_r.valid;
  assign wrap_done = (probe_cnt_r == LAST_IDX);
  assign emit      = (hit || empty) && close_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_LOOK) && (hit || empty) && (!emit || out_free);
  assign drop      = (state_r == ST_LOOK) && !hit && !empty && wrap_done;
  assign probe     = (state_r == ST_LOOK) && !hit && !empty && !wrap_done;
  assign addr_nxt  = (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;

  // Record update: fresh record for a new flow, then the packet applied
  always_comb begin
    if (empty) begin
      base           = '0;
      base.min_len   = 16'hFFFF;
      base.port      = dport_r;
      base.min_gap   = '1;
      base.last_time = now_r;
    end else begin
      base = rd_data_r;
    end
    hdr_len          = {10'd0, doff_r, 2'b00};
    gap              = now_r - base.last_time;
    upd              = base;
    upd.valid        = 1'b1;
    upd.key_addrs    = key_addrs_r;
    upd.key_ports    = key_ports_r;
    upd.count        = base.count + 32'd1;
    upd.min_len      = (payload_r < base.min_len) ? payload_r : base.min_len;
    upd.max_len      = (payload_r > base.max_len) ? payload_r : base.max_len;
    upd.total_len    = base.total_len + {32'd0, payload_r};
    upd.header_bytes = base.header_bytes + {32'd0, hdr_len};
    // zero last time skips the gap; zero min_gap is always replaced
    if ((base.last_time != '0) && ((base.min_gap == '0) || (gap < base.min_gap))) begin
      upd.min_gap = gap;
    end
    upd.last_time    = now_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept && pass) state_nxt = ST_LOOK;
      ST_LOOK:  if (commit || drop) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Memory control
  always_comb begin
    in_stall  = 1'b1;
    rd_addr   = addr_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = upd;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = hash_idx;
      end
      ST_LOOK: begin
        rd_addr = probe ? addr_nxt : addr_r;
        mem_we  = commit;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (commit && emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Item context and probe position
  always_ff @(posedge clk) begin
    if (accept) begin
      key_addrs_r <= {in_src_addr, in_dst_addr};
      key_ports_r <= {in_src_port, in_dst_port};
      dport_r     <= in_dst_port;
      payload_r   <= (in_ip_total_length > {10'd0, in_ip_header_words, 2'b00}) ?
                     (in_ip_total_length - {10'd0, in_ip_header_words, 2'b00}) : 16'd0;
      doff_r      <= in_tcp_data_offset;
      close_r     <= in_tcp_flags[FLAG_FIN] || in_tcp_flags[FLAG_RST];
      now_r       <= in_arrival_time;
      addr_r      <= hash_idx;
      probe_cnt_r <= '0;
    end else if (probe) begin
      addr_r      <= addr_nxt;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (commit && emit) begin
      out_rec_r <= upd;
      out_end_r <= now_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_packet_count       = out_rec_r.count;
  assign out_min_payload        = out_rec_r.min_len;
  assign out_max_payload        = out_rec_r.max_len;
  assign out_total_payload      = out_rec_r.total_len;
  assign out_flow_dst_port      = out_rec_r.port;
  assign out_total_header_bytes = out_rec_r.header_bytes;
  assign out_min_gap            = out_rec_r.min_gap;
  assign out_end_time           = out_end_r;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the TCP flow feature table: queued driver, scoreboard, random idling.
`timescale 1ns / 1ps
module tb_top;
  import tcpft_pkg::*;

  localparam int unsigned TABLE_SIZE = FLOW_ENTRIES_DEF;
  localparam int unsigned POOL_FLOWS = 48;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_AT = 6000;
  localparam int unsigned HOLD_LEN = 3000;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    bit [15:0] cap_len;
    bit [15:0] etype;
    bit [7:0]  proto;
    bit [31:0] saddr;
    bit [31:0] daddr;
    bit [15:0] sport;
    bit [15:0] dport;
    bit [15:0] tot_len;
    bit [3:0]  ihl;
    bit [3:0]  doff;
    bit [7:0]  flags;
    bit [63:0] stamp;
  } pkt_hdr_t;

  typedef struct {
    bit [31:0] pkts;
    bit [15:0] min_pay;
    bit [15:0] max_pay;
    bit [47:0] tot_pay;
    bit [15:0] port;
    bit [47:0] hdr_bytes;
    bit [63:0] min_gap;
    bit [63:0] end_stamp;
  } flow_stats_t;

  typedef struct {
    bit [31:0] pkts;
    bit [15:0] min_pay;
    bit [15:0] max_pay;
    bit [47:0] tot_pay;
    bit [15:0] port;
    bit [47:0] hdr_bytes;
    bit [63:0] min_gap;
    bit [63:0] last_seen;
  } flow_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_captured_length = '0;
  logic [15:0] in_ethertype = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [15:0] in_ip_total_length = '0;
  logic [3:0]  in_ip_header_words = '0;
  logic [3:0]  in_tcp_data_offset = '0;
  logic [7:0]  in_tcp_flags = '0;
  logic [63:0] in_arrival_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_packet_count;
  logic [15:0] out_min_payload;
  logic [15:0] out_max_payload;
  logic [47:0] out_total_payload;
  logic [15:0] out_flow_dst_port;
  logic [47:0] out_total_header_bytes;
  logic [63:0] out_min_gap;
  logic [63:0] out_end_time;

  tcp_flow_feature_table_unit dut (.*);

  pkt_hdr_t    pending_pkts[$];
  flow_stats_t closed_flows[$];
  flow_state_t flow_table[bit [95:0]];
  pkt_hdr_t    cur_pkt;
  int unsigned pkts_taken = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int unsigned rx_cycles = 0;
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;

  bit [31:0] pool_sa[POOL_FLOWS];
  bit [31:0] pool_da[POOL_FLOWS];
  bit [15:0] pool_sp[POOL_FLOWS];
  bit [15:0] pool_dp[POOL_FLOWS];
  bit [63:0] clock_ns = 64'd1000;

  initial forever #10 clk = ~clk;

  // Per-flow statistics update; returns 1 when the packet closes the flow
  function automatic bit update_flow(pkt_hdr_t p, output flow_stats_t r);
    bit [95:0] key;
    flow_state_t f;
    bit [63:0] gap;
    int pay;
    if (p.cap_len < MIN_FRAME_LEN || p.etype != ETYPE_IPV4 || p.proto != PROTO_TCP)
      return 1'b0;
    key = {p.saddr, p.daddr, p.sport, p.dport};
    if (!flow_table.exists(key)) begin
      if (flow_table.num() >= TABLE_SIZE) return 1'b0;
      f.pkts = '0;
      f.min_pay = 16'hFFFF;
      f.max_pay = '0;
      f.tot_pay = '0;
      f.port = p.dport;
      f.hdr_bytes = '0;
      f.min_gap = '1;
      f.last_seen = p.stamp;
    end else begin
      f = flow_table[key];
    end
    pay = int'(p.tot_len) - 4 * int'(p.ihl);
    if (pay < 0) pay = 0;
    f.pkts = f.pkts + 1;
    if (pay < f.min_pay) f.min_pay = pay[15:0];
    if (pay > f.max_pay) f.max_pay = pay[15:0];
    f.tot_pay = f.tot_pay + 48'(pay);
    // zero-gap quirk: a zero minimum is always replaced
    if (f.last_seen != 0) begin
      gap = p.stamp - f.last_seen;
      if (f.min_gap == 0 || gap < f.min_gap) f.min_gap = gap;
    end
    f.last_seen = p.stamp;
    f.hdr_bytes = f.hdr_bytes + 48'(4 * int'(p.doff));
    flow_table[key] = f;
    if (!p.flags[FLAG_FIN] && !p.flags[FLAG_RST]) return 1'b0;
    r.pkts = f.pkts;
    r.min_pay = f.min_pay;
    r.max_pay = f.max_pay;
    r.tot_pay = f.tot_pay;
    r.port = f.port;
    r.hdr_bytes = f.hdr_bytes;
    r.min_gap = f.min_gap;
    r.end_stamp = p.stamp;
    return 1'b1;
  endfunction

  function automatic pkt_hdr_t tcp_pkt(int idx, bit [15:0] tl, bit [3:0] ihl,
                                       bit [3:0] doff, bit [7:0] flags, bit [63:0] t);
    pkt_hdr_t p;
    p.cap_len = 16'd60;
    p.etype = ETYPE_IPV4;
    p.proto = PROTO_TCP;
    p.saddr = pool_sa[idx];
    p.daddr = pool_da[idx];
    p.sport = pool_sp[idx];
    p.dport = pool_dp[idx];
    p.tot_len = tl;
    p.ihl = ihl;
    p.doff = doff;
    p.flags = flags;
    p.stamp = t;
    return p;
  endfunction

  function automatic int draw_tx_gap();
    if ((pkts_taken / 150) % 4 == 1) return 0;
    return $urandom_range(0, 6);
  endfunction

  // Driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    bit take;
    int g;
    flow_stats_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        if (update_flow(cur_pkt, r)) closed_flows.push_back(r);
        pkts_taken++;
        g = draw_tx_gap();
      end else begin
        g = gap_left;
      end
      if (!in_valid || take) begin
        if (g == 0 && pending_pkts.size() > 0) begin
          cur_pkt = pending_pkts.pop_front();
          in_valid <= 1'b1;
          in_captured_length <= cur_pkt.cap_len;
          in_ethertype <= cur_pkt.etype;
          in_ip_protocol <= cur_pkt.proto;
          in_src_addr <= cur_pkt.saddr;
          in_dst_addr <= cur_pkt.daddr;
          in_src_port <= cur_pkt.sport;
          in_dst_port <= cur_pkt.dport;
          in_ip_total_length <= cur_pkt.tot_len;
          in_ip_header_words <= cur_pkt.ihl;
          in_tcp_data_offset <= cur_pkt.doff;
          in_tcp_flags <= cur_pkt.flags;
          in_arrival_time <= cur_pkt.stamp;
        end else begin
          in_valid <= 1'b0;
          if (g > 0) g--;
        end
      end
      gap_left = g;
    end
  end

  // Receiver stall: random per item, quiet windows, and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else begin
        if (out_valid && !out_stall)
          stall_left = ((rx_cycles / 2000) % 3 == 2) ? 0 : $urandom_range(0, 6);
        else if (stall_left > 0)
          stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  // Monitor: compare each result with the oldest expected record
  always @(posedge clk) begin
    flow_stats_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (closed_flows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, count %0d", out_packet_count);
      end else begin
        e = closed_flows.pop_front();
        if (out_packet_count !== e.pkts || out_min_payload !== e.min_pay ||
            out_max_payload !== e.max_pay || out_total_payload !== e.tot_pay ||
            out_flow_dst_port !== e.port || out_total_header_bytes !== e.hdr_bytes ||
            out_min_gap !== e.min_gap || out_end_time !== e.end_stamp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp cnt=%0d min=%0d max=%0d tot=%0d port=%0d hdr=%0d gap=%0h end=%0h",
                     e.pkts, e.min_pay, e.max_pay, e.tot_pay, e.port, e.hdr_bytes,
                     e.min_gap, e.end_stamp);
            $display("         got cnt=%0d min=%0d max=%0d tot=%0d port=%0d hdr=%0d gap=%0h end=%0h",
                     out_packet_count, out_min_payload, out_max_payload, out_total_payload,
                     out_flow_dst_port, out_total_header_bytes, out_min_gap, out_end_time);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    pkt_hdr_t p;
    int idx;
    int sel;
    int unsigned total_items;
    for (int i = 0; i < POOL_FLOWS; i++) begin
      pool_sa[i] = $urandom;
      pool_da[i] = $urandom;
      pool_sp[i] = 16'($urandom);
      pool_dp[i] = 16'($urandom);
    end
    // a few flows differ only in one key field
    pool_sa[1] = pool_sa[0]; pool_da[1] = pool_da[0]; pool_sp[1] = pool_sp[0];
    pool_sa[2] = pool_sa[0]; pool_da[2] = pool_da[0]; pool_dp[2] = pool_dp[0];
    pool_sa[3] = '1; pool_da[3] = '1; pool_sp[3] = '1; pool_dp[3] = '1;
    pool_sa[4] = '0; pool_da[4] = '0; pool_sp[4] = '0; pool_dp[4] = '0;

    // directed: filters at their edges
    p = tcp_pkt(5, 16'd100, 4'd5, 4'd5, 8'h01, 64'd500);
    p.cap_len = 16'd53; pending_pkts.push_back(p);
    p.etype = 16'h0801; p.cap_len = 16'd54; pending_pkts.push_back(p);
    p.etype = ETYPE_IPV4; p.proto = 8'd17; pending_pkts.push_back(p);
    p.proto = 8'hFF; pending_pkts.push_back(p);
    p.proto = PROTO_TCP; p.cap_len = 16'hFFFF; pending_pkts.push_back(p);
    // flow created at time zero keeps an all-ones gap until a nonzero last time
    pending_pkts.push_back(tcp_pkt(4, 16'd40, 4'd5, 4'd5, 8'h00, 64'd0));
    pending_pkts.push_back(tcp_pkt(4, 16'd20, 4'd15, 4'd0, 8'h01, 64'd0));
    pending_pkts.push_back(tcp_pkt(4, 16'hFFFF, 4'd0, 4'd15, 8'hFA, 64'd700));
    pending_pkts.push_back(tcp_pkt(4, 16'd0, 4'd0, 4'd15, 8'h04, 64'd900));
    // all-ones key, wrapping timestamps, both close flags
    pending_pkts.push_back(tcp_pkt(3, 16'd1500, 4'd5, 4'd8, 8'h00, 64'hFFFF_FFFF_FFFF_FFF0));
    pending_pkts.push_back(tcp_pkt(3, 16'd60, 4'd5, 4'd5, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_pkts.push_back(tcp_pkt(3, 16'd61, 4'd5, 4'd5, 8'h05, 64'd5));
    pending_pkts.push_back(tcp_pkt(3, 16'd2, 4'd1, 4'd5, 8'hFF, 64'd5));
    // near-duplicate keys and a kept record after FIN
    pending_pkts.push_back(tcp_pkt(0, 16'd300, 4'd5, 4'd5, 8'h01, 64'd1000));
    pending_pkts.push_back(tcp_pkt(1, 16'd300, 4'd5, 4'd5, 8'h04, 64'd1010));
    pending_pkts.push_back(tcp_pkt(2, 16'd300, 4'd5, 4'd5, 8'h01, 64'd1020));
    pending_pkts.push_back(tcp_pkt(0, 16'd301, 4'd5, 4'd5, 8'h01, 64'd1100));

    // random: mostly pool flows, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idx = $urandom_range(0, POOL_FLOWS - 1);
      sel = $urandom_range(0, 99);
      clock_ns = clock_ns + $urandom_range(1, 1000);
      p = tcp_pkt(idx, 16'($urandom), 4'($urandom), 4'($urandom), 8'($urandom) & 8'hFA,
                  clock_ns);
      if ($urandom_range(0, 3) == 0) p.tot_len = 16'($urandom_range(0, 1600));
      if ($urandom_range(0, 4) == 0) p.flags = 8'($urandom);
      if ($urandom_range(0, 19) == 0) p.stamp = {$urandom, $urandom};
      if ($urandom_range(0, 49) == 0) p.stamp = '0;
      p.cap_len = 16'($urandom_range(54, 65535));
      if (sel < 8) begin
        p.cap_len = 16'($urandom); p.etype = 16'($urandom); p.proto = 8'($urandom);
        p.saddr = $urandom; p.daddr = $urandom;
        p.sport = 16'($urandom); p.dport = 16'($urandom);
      end else if (sel < 11) begin
        p.cap_len = 16'($urandom_range(0, 53));
      end else if (sel < 14) begin
        p.proto = 8'($urandom);
      end else if (sel < 18) begin
        // fresh flow with random key
        p.saddr = $urandom; p.daddr = $urandom;
        p.sport = 16'($urandom); p.dport = 16'($urandom);
      end
      pending_pkts.push_back(p);
    end
    total_items = pending_pkts.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every item accepted, then every expected result seen
    while (pkts_taken < total_items) @(posedge clk);
    while (closed_flows.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
